FILE: src/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TLCC_ASSERT(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (expr)) else $error("tlcc assertion failed");
`define TLCC_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |-> (cons)) else $error("tlcc implication failed");
`define TLCC_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("tlcc next-cycle check failed");
`else
`define TLCC_ASSERT(lbl, expr)
`define TLCC_ASSERT_IMP(lbl, ante, cons)
`define TLCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/tlcc_pkg.sv
package tlcc_pkg;

  localparam int ROW_W = 14;
  localparam int CNT_W = 16;
  localparam int SUM_W = 32;
  localparam int TID_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd2;

  localparam logic [ROW_W-1:0] LINE_RST  = 14'd1920;
  localparam logic [ROW_W-1:0] CROSS_RST = 14'd400;
  localparam logic [ROW_W-1:0] SPEED_RST = 14'd800;

  localparam logic [1:0] CROSS_NONE = 2'd0;
  localparam logic [1:0] CROSS_DOWN = 2'd1;
  localparam logic [1:0] CROSS_UP   = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [TID_W-1:0] track_id;
    logic             track_active;
    logic [ROW_W-1:0] centroid_row;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] down_count;
    logic [CNT_W-1:0] up_count;
    logic [1:0]       crossed_now;
    logic [ROW_W-1:0] mean_speed;
  } out_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

FILE: src/tlcc_div.sv
module tlcc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tlcc_pkg::SUM_W-1:0]     dividend,
  input  logic [tlcc_pkg::CNT_W-1:0]     divisor,
  output logic                           done,
  output logic [tlcc_pkg::ROW_W-1:0]     quotient
);

  localparam int QW = tlcc_pkg::ROW_W;
  localparam int DW = tlcc_pkg::CNT_W;
  localparam int CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [DW:0]   trial;
  logic          ge;

  // quotient fits in QW bits since every sample adds at most one full row range,
  // so the upper dividend bits start below the divisor
  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      rem_nxt  = dividend[QW +: DW];
      quo_nxt  = dividend[QW-1:0];
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/tlcc_dp.sv
`include "assert_macros.svh"

module tlcc_dp #(
  parameter int MAX_TRACKS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlcc_pkg::cmd_t                     cmd,
  output tlcc_pkg::sts_t                     sts,
  input  tlcc_pkg::in_t                      in_data,
  output tlcc_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [tlcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlcc_pkg::ROW_W-1:0]         cfg_data
);

  localparam int RW = tlcc_pkg::ROW_W;
  localparam int NW = tlcc_pkg::CNT_W;
  localparam int SW = tlcc_pkg::SUM_W;
  // ids are TID_W bits wide, so no more than 2**TID_W entries can be reached
  localparam int DEPTH = (MAX_TRACKS < (1 << tlcc_pkg::TID_W)) ? MAX_TRACKS
                                                                 : (1 << tlcc_pkg::TID_W);
  localparam int IW = $clog2(DEPTH);

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
    return (v == tlcc_pkg::CNT_MAX) ? v : NW'(v + NW'(1));
  endfunction

  logic [RW-1:0] mem [DEPTH];

  tlcc_pkg::in_t  req_r;
  tlcc_pkg::out_t out_r;
  logic [RW-1:0]  prev_r;
  logic [RW-1:0]  line_r, cband_r, sband_r;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [NW-1:0]  tot_r, tot_nxt, down_r, down_nxt, up_r, up_nxt;
  logic [NW-1:0]  samples_r, samples_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [1:0]     crossed_r, crossed_nxt;

  logic [IW-1:0]  idx, in_idx;
  logic           hit;
  logic [RW-1:0]  cur;
  logic [RW:0]    l_pb, c_pb, p_pb, l_ps, c_ps, line_x, cur_x, prev_x;
  logic           down_hit, up_hit, in_sband;
  logic [RW-1:0]  absd;
  logic           div_done;
  logic [RW-1:0]  quotient;

  assign idx    = req_r.track_id[IW-1:0];
  assign in_idx = in_data.track_id[IW-1:0];
  assign hit    = 32'(req_r.track_id) < 32'(MAX_TRACKS);
  assign cur    = req_r.centroid_row;

  // band edges one bit wider so nothing wraps
  assign line_x = {1'b0, line_r};
  assign cur_x  = {1'b0, cur};
  assign prev_x = {1'b0, prev_r};
  assign l_pb   = line_x + {1'b0, cband_r};
  assign c_pb   = cur_x + {1'b0, cband_r};
  assign p_pb   = prev_x + {1'b0, cband_r};
  assign l_ps   = line_x + {1'b0, sband_r};
  assign c_ps   = cur_x + {1'b0, sband_r};

  // x > line - band is written as x + band > line
  assign down_hit = (cur > line_r) && (cur_x < l_pb) && (p_pb > line_x) && (prev_r < line_r);
  assign up_hit   = (c_pb > line_x) && (cur < line_r) && (prev_r > line_r) && (prev_x < l_pb);
  assign in_sband = (cur_x < l_ps) && (c_ps > line_x);
  assign absd     = (cur >= prev_r) ? RW'(cur - prev_r) : RW'(prev_r - cur);

  always_comb begin
    valid_nxt   = valid_r;
    tot_nxt     = tot_r;
    down_nxt    = down_r;
    up_nxt      = up_r;
    samples_nxt = samples_r;
    sum_nxt     = sum_r;
    crossed_nxt = crossed_r;
    if (cmd.calc) begin
      crossed_nxt = tlcc_pkg::CROSS_NONE;
      if (req_r.req_type) begin
        tot_nxt     = '0;
        down_nxt    = '0;
        up_nxt      = '0;
        samples_nxt = '0;
        sum_nxt     = '0;
      end else if (hit) begin
        if (!req_r.track_active) begin
          valid_nxt[idx] = 1'b0;
        end else begin
          if (valid_r[idx]) begin
            if (down_hit) begin
              crossed_nxt = tlcc_pkg::CROSS_DOWN;
              tot_nxt     = sat_inc(tot_r);
              down_nxt    = sat_inc(down_r);
            end else if (up_hit) begin
              crossed_nxt = tlcc_pkg::CROSS_UP;
              tot_nxt     = sat_inc(tot_r);
              up_nxt      = sat_inc(up_r);
            end
            if (in_sband && (samples_r != tlcc_pkg::CNT_MAX)) begin
              sum_nxt     = sum_r + SW'(absd);
              samples_nxt = samples_r + NW'(1);
            end
          end
          valid_nxt[idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      tot_r     <= '0;
      down_r    <= '0;
      up_r      <= '0;
      samples_r <= '0;
      sum_r     <= '0;
      crossed_r <= tlcc_pkg::CROSS_NONE;
      line_r    <= tlcc_pkg::LINE_RST;
      cband_r   <= tlcc_pkg::CROSS_RST;
      sband_r   <= tlcc_pkg::SPEED_RST;
    end else begin
      valid_r   <= valid_nxt;
      tot_r     <= tot_nxt;
      down_r    <= down_nxt;
      up_r      <= up_nxt;
      samples_r <= samples_nxt;
      sum_r     <= sum_nxt;
      crossed_r <= crossed_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tlcc_pkg::REG_LINE:  line_r  <= cfg_data;
          tlcc_pkg::REG_CROSS: cband_r <= cfg_data;
          tlcc_pkg::REG_SPEED: sband_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // track row table, read on accept, written in the update cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev_r <= mem[in_idx];
    end
    if (cmd.calc && !req_r.req_type && hit && req_r.track_active) begin
      mem[idx] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r.total_count <= tot_r;
      out_r.down_count  <= down_r;
      out_r.up_count    <= up_r;
      out_r.crossed_now <= crossed_r;
      out_r.mean_speed  <= (samples_r == '0) ? '0 : quotient;
    end
  end

  tlcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (samples_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.div_done = div_done;
  assign out_data     = out_r;

  `TLCC_ASSERT(a_sum_bound, (sum_r[SW-1:RW] < (SW-RW)'(samples_r)) || (samples_r == '0 && sum_r == '0))
  `TLCC_ASSERT_IMP(a_cross_counted, crossed_r != tlcc_pkg::CROSS_NONE, tot_r != '0)
  `TLCC_ASSERT_NEXT(a_restart_clears, cmd.calc && req_r.req_type, tot_r == '0 && samples_r == '0)

endmodule

FILE: src/tlcc_ctrl.sv
`include "assert_macros.svh"

module tlcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tlcc_pkg::cmd_t cmd,
  input  tlcc_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (out_free) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // result is done, waiting for the output register to drain
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TLCC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready)
  `TLCC_ASSERT_IMP(a_done_in_div, sts.div_done, state_r == S_DIV)
  `TLCC_ASSERT_NEXT(a_start_then_div, cmd.div_start, state_r == S_DIV)

endmodule

FILE: src/tracked_line_crossing_counter.sv
// tracked line crossing counter
// input channel (in_valid/in_ready/in_data): one request per track observation
// or restart. an observation updates the per-track row table and, when the
// track already has a stored row, tests for a crossing of the counting line and
// takes a speed sample inside the speed band. a restart clears the counters.
// result channel (out_valid/out_ready/out_data): one result per request with
// the saturating crossing counts, this request's crossing direction and the
// mean speed (speed sum over sample count, zero with no samples).
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): line position and
// the two band half widths; always ready, write only while no request is open.
// from accept to out_valid a request runs through the update cycle, the divider
// start, 14 steps of the one-bit-per-cycle divider and the output load.
// a new request is taken the cycle after the previous result is loaded into
// the output register, so the block takes no new request while one is still
// in its update, divider or output load steps.
// when the receiver stalls the finished result waits in the output register and
// the next request still runs; its result holds in the divider until the
// output register frees. reset clears the counters, track valid bits and
// config registers to their defaults; the row table itself is not cleared.
module tracked_line_crossing_counter #(
  parameter int MAX_TRACKS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tlcc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tlcc_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlcc_pkg::ROW_W-1:0]      cfg_data
);

  tlcc_pkg::cmd_t cmd;
  tlcc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tlcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tlcc_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

FILE: dv/tb_tracked_line_crossing_counter.sv
`timescale 1ns / 1ps

module tb_tracked_line_crossing_counter;

  localparam int ROW_W     = tlcc_pkg::ROW_W;
  localparam int CNT_W     = tlcc_pkg::CNT_W;
  localparam int SUM_W     = tlcc_pkg::SUM_W;
  localparam int TID_W     = tlcc_pkg::TID_W;
  localparam int CFG_IDX_W = tlcc_pkg::CFG_IDX_W;

  localparam int N_TRACKS = 64;
  localparam int ROW_MAX  = (1 << ROW_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tlcc_pkg::in_t        in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tlcc_pkg::out_t       out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data = '0;

  tracked_line_crossing_counter #(
    .MAX_TRACKS(N_TRACKS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracking table and counters as the block should hold them
  logic [ROW_W-1:0] last_row [N_TRACKS];
  logic             row_known [N_TRACKS];
  logic [CNT_W-1:0] n_total;
  logic [CNT_W-1:0] n_down;
  logic [CNT_W-1:0] n_up;
  logic [SUM_W-1:0] dist_sum;
  logic [CNT_W-1:0] dist_samples;
  logic [ROW_W-1:0] line_row;
  logic [ROW_W-1:0] cross_half;
  logic [ROW_W-1:0] speed_half;

  tlcc_pkg::in_t  obs_q [$];
  tlcc_pkg::out_t tallies [$];
  tlcc_pkg::out_t want;
  bit   allow_idle = 1'b1;
  int   obs_gap;
  int   stall_left;
  int   n_errors = 0;

  function automatic tlcc_pkg::out_t count_crossing(tlcc_pkg::in_t req);
    tlcc_pkg::out_t res;
    int   c;
    int   p;
    int   ln;
    int   cb;
    int   sb;
    int   d;
    logic [1:0] dir;
    dir = tlcc_pkg::CROSS_NONE;
    c = int'(req.centroid_row);
    if (req.req_type) begin
      n_total = '0;
      n_down = '0;
      n_up = '0;
      dist_sum = '0;
      dist_samples = '0;
    end else if (int'(req.track_id) < N_TRACKS) begin
      if (!req.track_active) begin
        row_known[req.track_id] = 1'b0;
      end else begin
        if (row_known[req.track_id]) begin
          p = int'(last_row[req.track_id]);
          ln = int'(line_row);
          cb = int'(cross_half);
          sb = int'(speed_half);
          if (c > ln && c < ln + cb && p > ln - cb && p < ln) begin
            dir = tlcc_pkg::CROSS_DOWN;
            if (n_total != tlcc_pkg::CNT_MAX) n_total++;
            if (n_down != tlcc_pkg::CNT_MAX) n_down++;
          end else if (c > ln - cb && c < ln && p > ln && p < ln + cb) begin
            dir = tlcc_pkg::CROSS_UP;
            if (n_total != tlcc_pkg::CNT_MAX) n_total++;
            if (n_up != tlcc_pkg::CNT_MAX) n_up++;
          end
          // samples stop at the count limit so the sum cannot overflow
          if (c < ln + sb && c > ln - sb && dist_samples != tlcc_pkg::CNT_MAX) begin
            d = (c > p) ? c - p : p - c;
            dist_sum = dist_sum + SUM_W'(d);
            dist_samples++;
          end
        end
        last_row[req.track_id] = req.centroid_row;
        row_known[req.track_id] = 1'b1;
      end
    end
    res.total_count = n_total;
    res.down_count = n_down;
    res.up_count = n_up;
    res.crossed_now = dir;
    res.mean_speed = (dist_samples != 0) ? ROW_W'(dist_sum / SUM_W'(dist_samples)) : '0;
    return res;
  endfunction

  function automatic void add_req(bit restart, int id, bit act, int row);
    tlcc_pkg::in_t r;
    r.req_type = restart;
    r.track_id = TID_W'(id);
    r.track_active = act;
    r.centroid_row = ROW_W'(row);
    obs_q.insert(obs_q.size(), r);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      obs_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) tallies.insert(tallies.size(), count_crossing(in_data));
      if (obs_gap > 0) begin
        obs_gap--;
        in_valid <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
        obs_gap = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else if (obs_q.size() != 0) begin
        in_data <= obs_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tallies.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want = tallies.pop_front();
          if (out_data.total_count !== want.total_count) begin
            $error("total_count: expected %0d, got %0d", want.total_count,
                   out_data.total_count);
            n_errors++;
          end
          if (out_data.down_count !== want.down_count) begin
            $error("down_count: expected %0d, got %0d", want.down_count,
                   out_data.down_count);
            n_errors++;
          end
          if (out_data.up_count !== want.up_count) begin
            $error("up_count: expected %0d, got %0d", want.up_count, out_data.up_count);
            n_errors++;
          end
          if (out_data.crossed_now !== want.crossed_now) begin
            $error("crossed_now: expected %0d, got %0d", want.crossed_now,
                   out_data.crossed_now);
            n_errors++;
          end
          if (out_data.mean_speed !== want.mean_speed) begin
            $error("mean_speed: expected %0d, got %0d", want.mean_speed,
                   out_data.mean_speed);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tlcc_pkg::REG_LINE:  line_row = val;
      tlcc_pkg::REG_CROSS: cross_half = val;
      tlcc_pkg::REG_SPEED: speed_half = val;
      default: ;
    endcase
  endtask

  task automatic set_bands(int ln, int cb, int sb);
    write_reg(tlcc_pkg::REG_SPEED, ROW_W'(sb));
    write_reg(tlcc_pkg::REG_LINE, ROW_W'(ln));
    write_reg(tlcc_pkg::REG_CROSS, ROW_W'(cb));
  endtask

  // sampled at the falling edge so every accept of this cycle is already queued
  task automatic drain();
    @(negedge clk);
    while (obs_q.size() != 0 || in_valid || tallies.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int n_items, bit idle);
    int pick;
    int id;
    int hot_base;
    int band;
    int off;
    int row_i;
    allow_idle = idle;
    hot_base = $urandom_range(0, N_TRACKS - 8);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) != 0) ? hot_base + $urandom_range(0, 7)
                                         : $urandom_range(0, N_TRACKS - 1);
      if (pick < 3) begin
        add_req(1'b1, $urandom_range(0, N_TRACKS - 1), $urandom_range(0, 1),
                $urandom_range(0, ROW_MAX));
      end else if (pick < 11) begin
        add_req(1'b0, id, 1'b0, $urandom_range(0, ROW_MAX));
      end else begin
        // mostly rows around the line so stored tracks keep crossing it
        if (pick < 64 || pick >= 85) begin
          band = (pick < 64) ? int'(cross_half) : int'(speed_half) + 4;
          off = $urandom_range(0, band);
          row_i = $urandom_range(0, 1) ? int'(line_row) + off : int'(line_row) - off;
          if (row_i < 0) row_i = 0;
          else if (row_i > ROW_MAX) row_i = ROW_MAX;
        end else begin
          row_i = $urandom_range(0, ROW_MAX);
        end
        add_req(1'b0, id, 1'b1, row_i);
      end
      // sender holds off until everything in flight has come back
      if (k == n_items / 2) drain();
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < N_TRACKS; i++) begin
      last_row[i] = '0;
      row_known[i] = 1'b0;
    end
    n_total = '0;
    n_down = '0;
    n_up = '0;
    dist_sum = '0;
    dist_samples = '0;
    line_row = tlcc_pkg::LINE_RST;
    cross_half = tlcc_pkg::CROSS_RST;
    speed_half = tlcc_pkg::SPEED_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests against the reset line and bands
    add_req(1'b1, 63, 1'b1, ROW_MAX);
    add_req(1'b0, 0, 1'b1, 1800);
    add_req(1'b0, 0, 1'b1, 2000);
    add_req(1'b0, 0, 1'b1, 1850);
    add_req(1'b0, 0, 1'b1, 1920);
    add_req(1'b0, 0, 1'b1, 1521);
    add_req(1'b0, 0, 1'b1, 2319);
    add_req(1'b0, 0, 1'b1, 1520);
    add_req(1'b0, 0, 1'b0, ROW_MAX);
    // track comes back: first sighting only stores the row
    add_req(1'b0, 0, 1'b1, 2100);
    add_req(1'b0, 0, 1'b1, 1700);
    add_req(1'b0, 63, 1'b1, ROW_MAX);
    add_req(1'b0, 63, 1'b1, 0);
    add_req(1'b0, 63, 1'b1, 1121);
    add_req(1'b0, 63, 1'b1, 2720);
    add_req(1'b0, 63, 1'b0, 0);
    add_req(1'b0, 42, 1'b0, 5000);
    add_req(1'b0, 21, 1'b1, 2320);
    add_req(1'b0, 21, 1'b1, 1600);
    add_req(1'b1, 0, 1'b0, 0);
    add_req(1'b0, 21, 1'b1, 2000);
    add_req(1'b0, 42, 1'b1, 1919);
    drain();

    set_bands(8000, 600, 1200);
    run_phase(200, 1'b1);
    // bands running past the low end and up to the high end of the row range
    set_bands(0, ROW_MAX, ROW_MAX);
    run_phase(160, 1'b1);
    set_bands(ROW_MAX, 300, 0);
    run_phase(160, 1'b0);
    set_bands($urandom_range(0, ROW_MAX), $urandom_range(1, 3000), $urandom_range(0, 6000));
    run_phase(200, 1'b1);
    // narrowest band that can still see a crossing
    set_bands(100, 2, 5);
    run_phase(130, 1'b1);
    set_bands(tlcc_pkg::LINE_RST, tlcc_pkg::CROSS_RST, tlcc_pkg::SPEED_RST);
    run_phase(230, 1'b0);

    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/tlcc_pkg.sv
src/tlcc_div.sv
src/tlcc_dp.sv
src/tlcc_ctrl.sv
src/tracked_line_crossing_counter.sv
dv/tb_tracked_line_crossing_counter.sv
